[sv/ocmk_pkg.sv]
// Shared types, constants and widths for the omni drive command kinematics block.
package ocmk_pkg;

  localparam int SETPOINT_W = 16;
  localparam int SPEED_W    = 25;
  localparam int GAIN_W     = 32;
  localparam int WEIGHT_W   = 10;
  localparam int CMD_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Wheel term in Q.16 and its split for the two partial products.
  localparam int X_W  = 43;
  localparam int XL_W = 21;
  localparam int XH_W = X_W - XL_W;

  localparam int M_TDATA_W = 128;
  localparam int S_TDATA_W = 8;

  localparam logic [16:0] HALF_ROOT3_Q16 = 17'd56757;
  localparam logic signed [SETPOINT_W-1:0] SETPOINT_MAX = 16'sd32767;

  localparam logic [GAIN_W-1:0]   GAIN_RESET   = 32'd219080;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 10'd100;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROT_WEIGHT = 2'd1;

  localparam int QUEUE_DEPTH_DEF = 2;

  typedef struct packed {
    logic signed [SETPOINT_W-1:0] forward;
    logic signed [SETPOINT_W-1:0] lateral;
    logic signed [SETPOINT_W-1:0] rotation;
    logic                         report;
  } cmd_entry_t;

endpackage

[sv/ocmk_front.sv]
// Command decoder: applies each byte to the setpoints and emits the updated set.
module ocmk_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        take,
  input  logic [ocmk_pkg::CMD_W-1:0]  cmd,
  output ocmk_pkg::cmd_entry_t        entry
);
  import ocmk_pkg::*;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 8'h5A; // Z
  localparam logic [CMD_W-1:0] CMD_REPORT = 8'h53; // S
  localparam logic [CMD_W-1:0] CMD_F_UP1  = 8'h61; // a
  localparam logic [CMD_W-1:0] CMD_F_DN1  = 8'h62; // b
  localparam logic [CMD_W-1:0] CMD_F_UP10 = 8'h41; // A
  localparam logic [CMD_W-1:0] CMD_F_DN10 = 8'h42; // B
  localparam logic [CMD_W-1:0] CMD_L_UP1  = 8'h63; // c
  localparam logic [CMD_W-1:0] CMD_L_DN1  = 8'h64; // d
  localparam logic [CMD_W-1:0] CMD_L_UP10 = 8'h43; // C
  localparam logic [CMD_W-1:0] CMD_L_DN10 = 8'h44; // D
  localparam logic [CMD_W-1:0] CMD_R_UP1  = 8'h65; // e
  localparam logic [CMD_W-1:0] CMD_R_DN1  = 8'h66; // f
  localparam logic [CMD_W-1:0] CMD_R_UP10 = 8'h45; // E
  localparam logic [CMD_W-1:0] CMD_R_DN10 = 8'h46; // F

  logic signed [SETPOINT_W-1:0] forward, forward_next;
  logic signed [SETPOINT_W-1:0] lateral, lateral_next;
  logic signed [SETPOINT_W-1:0] rotation, rotation_next;
  logic                         report;

  // Add a small step and clamp to the symmetric setpoint range.
  function automatic logic signed [SETPOINT_W-1:0] step_sat(
    input logic signed [SETPOINT_W-1:0] v,
    input logic signed [4:0]            d
  );
    logic signed [SETPOINT_W:0] s;
    s = {v[SETPOINT_W-1], v} + {{(SETPOINT_W-4){d[4]}}, d};
    if (s > $signed({SETPOINT_MAX[SETPOINT_W-1], SETPOINT_MAX})) begin
      return SETPOINT_MAX;
    end else if (s < -$signed({SETPOINT_MAX[SETPOINT_W-1], SETPOINT_MAX})) begin
      return -SETPOINT_MAX;
    end else begin
      return s[SETPOINT_W-1:0];
    end
  endfunction

  always_comb begin
    forward_next  = forward;
    lateral_next  = lateral;
    rotation_next = rotation;
    report        = 1'b0;
    case (cmd)
      CMD_CLEAR: begin
        forward_next  = '0;
        lateral_next  = '0;
        rotation_next = '0;
      end
      CMD_F_UP1:  forward_next  = step_sat(forward, 5'sd1);
      CMD_F_DN1:  forward_next  = step_sat(forward, -5'sd1);
      CMD_F_UP10: forward_next  = step_sat(forward, 5'sd10);
      CMD_F_DN10: forward_next  = step_sat(forward, -5'sd10);
      CMD_L_UP1:  lateral_next  = step_sat(lateral, 5'sd1);
      CMD_L_DN1:  lateral_next  = step_sat(lateral, -5'sd1);
      CMD_L_UP10: lateral_next  = step_sat(lateral, 5'sd10);
      CMD_L_DN10: lateral_next  = step_sat(lateral, -5'sd10);
      CMD_R_UP1:  rotation_next = step_sat(rotation, 5'sd1);
      CMD_R_DN1:  rotation_next = step_sat(rotation, -5'sd1);
      CMD_R_UP10: rotation_next = step_sat(rotation, 5'sd10);
      CMD_R_DN10: rotation_next = step_sat(rotation, -5'sd10);
      CMD_REPORT: report = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      forward  <= '0;
      lateral  <= '0;
      rotation <= '0;
    end else if (take) begin
      forward  <= forward_next;
      lateral  <= lateral_next;
      rotation <= rotation_next;
    end
  end

  assign entry.forward  = forward_next;
  assign entry.lateral  = lateral_next;
  assign entry.rotation = rotation_next;
  assign entry.report   = report;

endmodule

[sv/ocmk_queue.sv]
// Short FIFO of decoded setpoint sets between the decoder and the kinematics engine.
module ocmk_queue #(
  parameter int DEPTH = ocmk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ocmk_pkg::cmd_entry_t push_data,
  input  logic                 pop,
  output ocmk_pkg::cmd_entry_t pop_data,
  output logic                 full,
  output logic                 empty
);
  import ocmk_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_entry_t    mem [0:DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign pop_data = mem[rd_ptr];
  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);

endmodule

[sv/ocmk_back.sv]
// Kinematics engine: forms the three wheel terms, scales them by the gain and drives the result.
module ocmk_back (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [ocmk_pkg::GAIN_W-1:0]        speed_gain,
  input  logic [ocmk_pkg::WEIGHT_W-1:0]      rotation_weight,
  input  logic                               q_empty,
  input  ocmk_pkg::cmd_entry_t               q_data,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ocmk_pkg::M_TDATA_W-1:0]     m_tdata,
  output logic                               m_tuser
);
  import ocmk_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_PROD = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam int W_W   = WEIGHT_W + SETPOINT_W + 1;
  localparam int HL_W  = 17 + SETPOINT_W;
  localparam int PH_W  = GAIN_W + 1 + XH_W;
  localparam int PL_W  = GAIN_W + XL_W;
  localparam int SUM_W = PH_W + XL_W;
  localparam int R_W   = SUM_W - GAIN_W;

  localparam logic signed [R_W-1:0] SPD_MAX = R_W'(2 ** (SPEED_W - 1) - 1);
  localparam logic signed [R_W-1:0] SPD_MIN = -R_W'(2 ** (SPEED_W - 1));

  logic [2:0]                   state;
  logic [1:0]                   wheel;
  cmd_entry_t                   cur;
  logic signed [W_W-1:0]        w_term;
  logic signed [HL_W-1:0]       lat_term;
  logic signed [X_W-1:0]        x_term [0:2];
  logic signed [PH_W-1:0]       prod_hi;
  logic [PL_W-1:0]              prod_lo;
  logic [1:0]                   prod_wheel;
  logic                         prod_vld;
  logic signed [SPEED_W-1:0]    speed [0:2];

  logic signed [X_W-1:0]        fx, wx, hx, xa, xb, xc, xsel;
  logic signed [SUM_W-1:0]      full_sum;
  logic signed [R_W-1:0]        scaled;
  logic signed [SPEED_W-1:0]    scaled_sat;
  logic                         out_free;

  // Wheel terms in Q.16: forward is halved exactly for wheels b and c, lateral carries sqrt3/2.
  always_comb begin
    fx = {{(X_W-SETPOINT_W){cur.forward[SETPOINT_W-1]}}, cur.forward};
    wx = {{(X_W-W_W){w_term[W_W-1]}}, w_term};
    hx = {{(X_W-HL_W){lat_term[HL_W-1]}}, lat_term};
    xa = (fx + wx) <<< 16;
    xb = (wx <<< 16) - (fx <<< 15) - hx;
    xc = (wx <<< 16) - (fx <<< 15) + hx;
  end

  assign xsel = x_term[wheel];

  // Exact gain * X, then floor by dropping 32 fraction bits and clamp to the speed range.
  always_comb begin
    full_sum = {prod_hi, {XL_W{1'b0}}} + {{(SUM_W-PL_W){1'b0}}, prod_lo};
    scaled   = full_sum[SUM_W-1:GAIN_W];
    if (scaled > SPD_MAX) begin
      scaled_sat = SPD_MAX[SPEED_W-1:0];
    end else if (scaled < SPD_MIN) begin
      scaled_sat = SPD_MIN[SPEED_W-1:0];
    end else begin
      scaled_sat = scaled[SPEED_W-1:0];
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign q_pop    = (state == ST_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur <= q_data;
      end
      ST_MUL: begin
        w_term   <= $signed({{(W_W-WEIGHT_W){1'b0}}, rotation_weight})
                  * $signed({{(W_W-SETPOINT_W){cur.rotation[SETPOINT_W-1]}}, cur.rotation});
        lat_term <= $signed({{(HL_W-17){1'b0}}, HALF_ROOT3_Q16})
                  * $signed({{(HL_W-SETPOINT_W){cur.lateral[SETPOINT_W-1]}}, cur.lateral});
      end
      ST_SUM: begin
        x_term[0] <= xa;
        x_term[1] <= xb;
        x_term[2] <= xc;
      end
      ST_PROD: begin
        prod_hi    <= $signed({{(PH_W-GAIN_W){1'b0}}, speed_gain})
                    * $signed({{(PH_W-XH_W){xsel[X_W-1]}}, xsel[X_W-1:XL_W]});
        prod_lo    <= {{(PL_W-GAIN_W){1'b0}}, speed_gain}
                    * {{(PL_W-XL_W){1'b0}}, xsel[XL_W-1:0]};
        prod_wheel <= wheel;
      end
      default: ;
    endcase
    if (prod_vld) begin
      speed[prod_wheel] <= scaled_sat;
    end
    if (state == ST_EMIT && out_free) begin
      m_tdata <= {{(M_TDATA_W - 3*SPEED_W - 3*SETPOINT_W){1'b0}},
                  cur.rotation, cur.lateral, cur.forward,
                  speed[2], speed[1], speed[0]};
      m_tuser <= cur.report;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wheel    <= '0;
      prod_vld <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      prod_vld <= (state == ST_PROD);
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: state <= ST_SUM;
        ST_SUM: begin
          wheel <= '0;
          state <= ST_PROD;
        end
        ST_PROD: begin
          if (wheel == 2'd2) begin
            state <= ST_FIN;
          end else begin
            wheel <= wheel + 1'b1;
          end
        end
        ST_FIN: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/omni_drive_command_kinematics.sv]
// Top level of the omni drive command decoder and three-wheel inverse kinematics.
//
// Slave stream (s_*): one ASCII command byte per beat in s_tdata[7:0]. Each byte
// steps, clears or leaves the forward, lateral and rotation setpoints and always
// yields exactly one master beat.
// Master stream (m_*): three Q8.16 wheel speeds, the three setpoints after the
// byte, and in m_tuser the status request flag (byte was 'S').
// Config channel (cfg_*): index 0 writes speed_gain (Q0.32), index 1 writes
// rotation_weight; other indexes are dropped. Always ready; write only while idle.
// The decoder takes a byte and queues the updated setpoints; the kinematics
// engine then works one beat at a time through its states in order: a pop, the
// small weight and sqrt3/2 multiplies, the wheel sums, one pass per wheel on the
// shared gain multiplier pair, a scale and clamp, and a load of the output
// register. The engine pops no new beat until it has loaded the current one.
// When m_tready is low the output register holds its beat, the engine parks,
// the queue fills and s_tready drops once it is full.
// Reset clears the setpoints, the queue and m_tvalid and restores the register
// reset values.
module omni_drive_command_kinematics #(
  parameter int QUEUE_DEPTH = ocmk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ocmk_pkg::S_TDATA_W-1:0]      s_tdata,   // [7:0] command_byte
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [24:0] wheel_a_speed, [49:25] wheel_b_speed, [74:50] wheel_c_speed,
  // [90:75] forward_value, [106:91] lateral_value, [122:107] rotation_value,
  // [127:123] zero
  output logic [ocmk_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                                m_tuser,   // [0] report_request
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ocmk_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ocmk_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ocmk_pkg::*;

  logic [GAIN_W-1:0]   speed_gain;
  logic [WEIGHT_W-1:0] rotation_weight;
  logic                take;
  cmd_entry_t          front_entry;
  cmd_entry_t          q_data;
  logic                q_full;
  logic                q_empty;
  logic                q_pop;

  // Hold the registers; accept every write, drop unknown indexes.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain      <= GAIN_RESET;
      rotation_weight <= WEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SPEED_GAIN: speed_gain      <= cfg_data[GAIN_W-1:0];
        REG_ROT_WEIGHT: rotation_weight <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Take a byte whenever the queue has room.
  assign s_tready = !q_full;
  assign take     = s_tvalid && s_tready;

  ocmk_front u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .cmd   (s_tdata[CMD_W-1:0]),
    .entry (front_entry)
  );

  ocmk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data (front_entry),
    .pop       (q_pop),
    .pop_data  (q_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  ocmk_back u_back (
    .clk             (clk),
    .rst             (rst),
    .speed_gain      (speed_gain),
    .rotation_weight (rotation_weight),
    .q_empty         (q_empty),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser)
  );

  // The engine never pops an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // Queued setpoints stay inside the symmetric range.
  a_setpoint_range: assert property (@(posedge clk) disable iff (rst)
    take |-> (front_entry.forward != -16'sd32768) && (front_entry.lateral != -16'sd32768)
             && (front_entry.rotation != -16'sd32768))
    else $error("setpoint left its range");

  // A pushed byte leaves the queue non-empty on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    take |=> !q_empty)
    else $error("pushed beat not visible in queue");

  // Reported forward and lateral setpoints never exceed the clamp either.
  a_out_forward: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[90:75] != 16'h8000) && (m_tdata[106:91] != 16'h8000))
    else $error("output setpoint out of range");

endmodule

[dv/omni_drive_command_kinematics_test.sv]
// Testbench for omni_drive_command_kinematics: command stream, setpoint and wheel speed checks.
`timescale 1ns / 1ps

import ocmk_pkg::*;

// Command characters
localparam logic [CMD_W-1:0] CMD_CLEAR     = "Z";
localparam logic [CMD_W-1:0] CMD_STATUS    = "S";
localparam logic [CMD_W-1:0] CMD_FWD_INC   = "a";
localparam logic [CMD_W-1:0] CMD_FWD_DEC   = "b";
localparam logic [CMD_W-1:0] CMD_FWD_INC10 = "A";
localparam logic [CMD_W-1:0] CMD_FWD_DEC10 = "B";
localparam logic [CMD_W-1:0] CMD_LAT_INC   = "c";
localparam logic [CMD_W-1:0] CMD_LAT_DEC   = "d";
localparam logic [CMD_W-1:0] CMD_LAT_INC10 = "C";
localparam logic [CMD_W-1:0] CMD_LAT_DEC10 = "D";
localparam logic [CMD_W-1:0] CMD_ROT_INC   = "e";
localparam logic [CMD_W-1:0] CMD_ROT_DEC   = "f";
localparam logic [CMD_W-1:0] CMD_ROT_INC10 = "E";
localparam logic [CMD_W-1:0] CMD_ROT_DEC10 = "F";

// Register indexes with no register behind them
localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

localparam longint WHEEL_MAX = 16777215;
localparam longint WHEEL_MIN = -16777216;

typedef struct packed {
  logic signed [SPEED_W-1:0]    a_speed;
  logic signed [SPEED_W-1:0]    b_speed;
  logic signed [SPEED_W-1:0]    c_speed;
  logic signed [SETPOINT_W-1:0] fwd;
  logic signed [SETPOINT_W-1:0] lat;
  logic signed [SETPOINT_W-1:0] rot;
  logic                         report;
} wheel_beat_t;

class kin_scoreboard;
  logic [GAIN_W-1:0]            gain;
  logic [WEIGHT_W-1:0]          weight;
  logic signed [SETPOINT_W-1:0] fwd, lat, rot;
  wheel_beat_t                  wheel_beats_due[$];
  int                           errors;
  int                           beats_checked;

  function void reset_state();
    gain   = GAIN_RESET;
    weight = WEIGHT_RESET;
    fwd    = '0;
    lat    = '0;
    rot    = '0;
    wheel_beats_due.delete();
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_SPEED_GAIN: gain = data;
      REG_ROT_WEIGHT: weight = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  function logic signed [SETPOINT_W-1:0] step_clamp(logic signed [SETPOINT_W-1:0] v, int d);
    int r;
    r = int'(v) + d;
    if (r > int'(SETPOINT_MAX)) r = int'(SETPOINT_MAX);
    if (r < -int'(SETPOINT_MAX)) r = -int'(SETPOINT_MAX);
    return r[SETPOINT_W-1:0];
  endfunction

  // floor(gain * term / 2^32), clamped to the 25-bit speed range
  function logic signed [SPEED_W-1:0] scale_wheel(longint term_q16);
    logic signed [96:0] gain_wide, term_wide, prod;
    gain_wide = {65'd0, gain};
    term_wide = term_q16;
    prod = (gain_wide * term_wide) >>> 32;
    if (prod > WHEEL_MAX) prod = WHEEL_MAX;
    if (prod < WHEEL_MIN) prod = WHEEL_MIN;
    return prod[SPEED_W-1:0];
  endfunction

  function void note_command(logic [CMD_W-1:0] c);
    wheel_beat_t exp;
    longint      f, l, wr;
    exp = '0;
    case (c)
      CMD_CLEAR: begin
        fwd = '0;
        lat = '0;
        rot = '0;
      end
      CMD_FWD_INC:   fwd = step_clamp(fwd, 1);
      CMD_FWD_DEC:   fwd = step_clamp(fwd, -1);
      CMD_FWD_INC10: fwd = step_clamp(fwd, 10);
      CMD_FWD_DEC10: fwd = step_clamp(fwd, -10);
      CMD_LAT_INC:   lat = step_clamp(lat, 1);
      CMD_LAT_DEC:   lat = step_clamp(lat, -1);
      CMD_LAT_INC10: lat = step_clamp(lat, 10);
      CMD_LAT_DEC10: lat = step_clamp(lat, -10);
      CMD_ROT_INC:   rot = step_clamp(rot, 1);
      CMD_ROT_DEC:   rot = step_clamp(rot, -1);
      CMD_ROT_INC10: rot = step_clamp(rot, 10);
      CMD_ROT_DEC10: rot = step_clamp(rot, -10);
      CMD_STATUS:    exp.report = 1'b1;
      default: ;
    endcase
    f  = longint'(fwd);
    l  = longint'(lat);
    wr = longint'(weight) * longint'(rot);
    exp.a_speed = scale_wheel((f + wr) * 65536);
    exp.b_speed = scale_wheel(-f * 32768 - longint'(HALF_ROOT3_Q16) * l + wr * 65536);
    exp.c_speed = scale_wheel(-f * 32768 + longint'(HALF_ROOT3_Q16) * l + wr * 65536);
    exp.fwd = fwd;
    exp.lat = lat;
    exp.rot = rot;
    wheel_beats_due.push_back(exp);
  endfunction

  function void compare_field(string name, longint exp, longint act);
    if (exp != act) begin
      $error("%s: expected %0d, actual %0d", name, exp, act);
      errors++;
    end
  endfunction

  function void check_beat(logic [M_TDATA_W-1:0] tdata, logic tuser);
    wheel_beat_t exp;
    if (wheel_beats_due.size() == 0) begin
      $error("output beat with no command pending: tdata %h", tdata);
      errors++;
      return;
    end
    exp = wheel_beats_due.pop_front();
    beats_checked++;
    compare_field("wheel_a_speed", exp.a_speed, $signed(tdata[24:0]));
    compare_field("wheel_b_speed", exp.b_speed, $signed(tdata[49:25]));
    compare_field("wheel_c_speed", exp.c_speed, $signed(tdata[74:50]));
    compare_field("forward_value", exp.fwd, $signed(tdata[90:75]));
    compare_field("lateral_value", exp.lat, $signed(tdata[106:91]));
    compare_field("rotation_value", exp.rot, $signed(tdata[122:107]));
    compare_field("report_request", exp.report, tuser);
  endfunction

  function int pending();
    return wheel_beats_due.size();
  endfunction
endclass

module omni_drive_command_kinematics_test;

  // Allow the watchdog plenty of margin beyond the slowest legal run.
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int IDLE_PCT      = 29;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS   = 275;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  kin_scoreboard sb = new();

  // Idling control shared by both sides; hold_request asks the receiver for a long stall.
  bit idle_on      = 1'b1;
  bit hold_request = 1'b0;
  bit hold_sent    = 1'b0;
  int cycles       = 0;
  int commands_sent = 0;
  int settings_used = 0;

  // Step commands used by the well-formed part of the random stimulus (clear is drawn apart).
  logic [CMD_W-1:0] step_cmds [13] = '{
    CMD_FWD_INC, CMD_FWD_DEC, CMD_FWD_INC10, CMD_FWD_DEC10,
    CMD_LAT_INC, CMD_LAT_DEC, CMD_LAT_INC10, CMD_LAT_DEC10,
    CMD_ROT_INC, CMD_ROT_DEC, CMD_ROT_INC10, CMD_ROT_DEC10,
    CMD_STATUS
  };

  omni_drive_command_kinematics uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: end the run with a fail once the cycle limit is passed.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("omni_drive_command_kinematics regression: fail");
        $finish;
      end
    end
  end

  // Receiver: check every accepted beat, then pick tready for the next cycle.
  // A hold-off is counted here so the sender keeps pushing while the block backs up.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(idle_on && ($urandom_range(99) < IDLE_PCT));
      end
    end
  end

  // Offer one command beat, with random gaps in front, and wait for acceptance.
  task automatic send_command(input logic [CMD_W-1:0] c);
    if (idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_tvalid <= 1'b0;
        s_tdata  <= S_TDATA_W'($urandom_range(255));
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    do @(posedge clk); while (!s_tready);
    sb.note_command(c);
    commands_sent++;
  endtask

  // Drop valid and wait until every outstanding wheel beat has come back.
  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Write both registers, plus a stray write to an index that must be ignored.
  task automatic apply_setting(input logic [GAIN_W-1:0] gain, input logic [WEIGHT_W-1:0] weight);
    cfg_write(REG_SPEED_GAIN, gain);
    cfg_write(($urandom_range(1) != 0) ? REG_UNUSED_2 : REG_UNUSED_3, $urandom);
    cfg_write(REG_ROT_WEIGHT, {22'd0, weight});
    settings_used++;
  endtask

  // Mostly step commands with occasional repeated runs, some clears, some noise bytes.
  task automatic send_random_command();
    int               pick;
    int               run;
    logic [CMD_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 3) begin
      send_command(CMD_CLEAR);
    end else if (pick < 20) begin
      send_command(CMD_W'($urandom_range(255)));
    end else begin
      c = step_cmds[$urandom_range(12)];
      run = ($urandom_range(9) == 0) ? $urandom_range(40, 5) : 1;
      repeat (run) send_command(c);
    end
  endtask

  initial begin
    int start_count;
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every command and a few unknown bytes at the reset setting.
    send_command(CMD_STATUS);
    send_command(CMD_FWD_INC);
    send_command(CMD_FWD_DEC);
    send_command(CMD_FWD_INC10);
    send_command(CMD_FWD_DEC10);
    send_command(CMD_LAT_INC);
    send_command(CMD_LAT_DEC);
    send_command(CMD_LAT_INC10);
    send_command(CMD_LAT_DEC10);
    send_command(CMD_ROT_INC);
    send_command(CMD_ROT_DEC);
    send_command(CMD_ROT_INC10);
    send_command(CMD_ROT_DEC10);
    send_command(CMD_FWD_INC10);
    send_command(CMD_CLEAR);
    send_command(8'h00);
    send_command(8'hFF);
    send_command("z");
    drain_outputs();

    // Full gain and weight: a small rotation pushes every wheel into the speed clamp.
    apply_setting('1, '1);
    send_command(CMD_ROT_INC10);
    send_command(CMD_ROT_DEC10);
    send_command(CMD_ROT_DEC10);
    send_command(CMD_STATUS);
    drain_outputs();

    // Random phases, each under its own register setting.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_setting(GAIN_RESET, WEIGHT_RESET);
        1: apply_setting('0, '0);
        2: apply_setting('1, '1);
        default: apply_setting($urandom, WEIGHT_W'($urandom_range(1023)));
      endcase
      start_count = commands_sent;
      while (commands_sent - start_count < PHASE_ITEMS) begin
        // Quiet stretch: no idling on either side for a while.
        idle_on = !(phase == 1 && (commands_sent - start_count) inside {[40:220]});
        if (phase == 2 && !hold_sent && (commands_sent - start_count) >= 100) begin
          hold_request = 1'b1;
          hold_sent    = 1'b1;
        end
        if (phase == 3 && (commands_sent - start_count) == 150) drain_outputs();
        send_random_command();
      end
      idle_on = 1'b1;
      drain_outputs();
    end

    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d command beats (%0d checked) across %0d register settings,",
             commands_sent, sb.beats_checked, settings_used);
    $display("all commands, noise bytes, speed clamps, a long receiver stall and full drains");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("omni_drive_command_kinematics regression: pass");
    end else begin
      $display("omni_drive_command_kinematics regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
sv/ocmk_pkg.sv
sv/ocmk_front.sv
sv/ocmk_queue.sv
sv/ocmk_back.sv
sv/omni_drive_command_kinematics.sv
dv/omni_drive_command_kinematics_test.sv
